### hdl/pl_pkg.sv
package pl_pkg;

  localparam int FUNC_W    = 3;
  localparam int POS_W     = 7;
  localparam int VAL_W     = 32;
  localparam int LEN_W     = 7;
  localparam int CNT_MAX_W = 11;

  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_LOCATE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  typedef struct packed {
    logic                 ins;
    logic                 del;
    logic                 rd;
    logic                 loc;
    logic [POS_W-1:0]     idx;
    logic [CNT_MAX_W-1:0] cnt;
  } cell_cmd_t;

endpackage

### hdl/pl_in_if.sv
interface pl_in_if;
  logic                            valid;
  logic                            ready;
  logic [pl_pkg::FUNC_W-1:0]       func;
  logic [pl_pkg::POS_W-1:0]        position;
  logic signed [pl_pkg::VAL_W-1:0] value_in;

  modport source (output valid, output func, output position, output value_in, input ready);
  modport sink   (input valid, input func, input position, input value_in, output ready);
endinterface

### hdl/pl_out_if.sv
interface pl_out_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic signed [pl_pkg::VAL_W-1:0] value_out;
  logic [pl_pkg::POS_W-1:0]        found_position;
  logic [pl_pkg::LEN_W-1:0]        length;
  logic                            empty_res;

  modport source (output valid, output ok, output value_out, output found_position,
                  output length, output empty_res, input ready);
  modport sink   (input valid, input ok, input value_out, input found_position,
                  input length, input empty_res, output ready);
endinterface

### hdl/pl_cell.sv
module pl_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pl_pkg::cell_cmd_t     cmd,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] prev_data,
  input  logic [DATA_WIDTH-1:0] next_data,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  hit_o,
  output logic [DATA_WIDTH-1:0] sel_data_o
);
  import pl_pkg::*;

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  hit_r, hit_nxt;
  logic                  at_pos, past_pos, live;

  assign at_pos   = (int'(cmd.idx) == IDX);
  assign past_pos = (int'(cmd.idx) < IDX);
  assign live     = (IDX < int'(cmd.cnt));

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins && past_pos) begin
      data_nxt = prev_data;
    end else if (cmd.ins && at_pos) begin
      data_nxt = key;
    end else if (cmd.del && (at_pos || past_pos)) begin
      data_nxt = next_data;
    end
  end

  always_comb begin
    hit_nxt = hit_r;
    if (cmd.rd) begin
      hit_nxt = at_pos;
    end else if (cmd.loc) begin
      hit_nxt = live && (data_r == key);
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign data_o     = data_r;
  assign hit_o      = hit_r;
  assign sel_data_o = hit_r ? data_r : '0;

endmodule

### hdl/positional_list_engine.sv
// Channel   Dir  Word
// in_chan   in   func, position, value_in
// out_chan  out  ok, value_out, found_position, length, empty_res
//
// One request passes through three steps: accept, cell update, result register.
// A new request is accepted once the previous result sits in the output register.
// The output register lets the next request enter while a result waits for ready.
// Reset (rst_n low, synchronous) empties the list; cell contents are not cleared.
// A stalled result holds the engine in its last step until out_chan.ready.
module positional_list_engine #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic     clk,
  input logic     rst_n,
  pl_in_if.sink   in_chan,
  pl_out_if.source out_chan
);
  import pl_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DONE} state_t;

  state_t                st_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  cell_cmd_t             cmd_r, cmd_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_in;
  logic [FUNC_W-1:0]     op_r;
  logic                  ok_r, ok_nxt;

  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [VAL_W-1:0]      out_value_r;
  logic [POS_W-1:0]      out_fpos_r;
  logic [LEN_W-1:0]      out_len_r;
  logic                  out_empty_r;

  logic                  in_accept;
  logic [CMP_W-1:0]      pos_w, cnt_w;
  logic                  ins_ok, in_rng;

  logic [DATA_WIDTH-1:0] data_w [DEPTH];
  logic [DATA_WIDTH-1:0] sel_w  [DEPTH];
  logic [DEPTH-1:0]      hit_w;
  logic [DATA_WIDTH-1:0] rd_val;
  logic [POS_W-1:0]      fpos;

  assign in_chan.ready = (st_r == ST_IDLE);
  assign in_accept     = in_chan.valid && in_chan.ready;

  assign key_in = DATA_WIDTH'(in_chan.value_in);
  assign pos_w  = CMP_W'(in_chan.position);
  assign cnt_w  = CMP_W'(cnt_r);
  assign ins_ok = (in_chan.position != '0) && (pos_w <= cnt_w + CMP_W'(1))
                  && (cnt_w < CMP_W'(DEPTH));
  assign in_rng = (in_chan.position != '0) && (pos_w <= cnt_w);

  always_comb begin
    cmd_nxt     = '0;
    cmd_nxt.idx = in_chan.position - POS_W'(1);
    cmd_nxt.cnt = CNT_MAX_W'(cnt_r);
    cnt_nxt     = cnt_r;
    ok_nxt      = 1'b0;
    unique case (in_chan.func)
      FN_INSERT: begin
        ok_nxt      = ins_ok;
        cmd_nxt.ins = ins_ok;
        if (ins_ok) cnt_nxt = cnt_r + CNT_W'(1);
      end
      FN_DELETE: begin
        ok_nxt      = in_rng;
        cmd_nxt.del = in_rng;
        if (in_rng) cnt_nxt = cnt_r - CNT_W'(1);
      end
      FN_READ: begin
        ok_nxt     = in_rng;
        cmd_nxt.rd = in_rng;
      end
      FN_LOCATE: begin
        cmd_nxt.loc = 1'b1;
      end
      FN_CLEAR: begin
        ok_nxt  = 1'b1;
        cnt_nxt = '0;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_d, next_d;
    if (g == 0) begin : g_first
      assign prev_d = key_r;
    end else begin : g_mid
      assign prev_d = data_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_d = data_w[g];
    end else begin : g_inner
      assign next_d = data_w[g+1];
    end
    pl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd_r),
      .key        (key_r),
      .prev_data  (prev_d),
      .next_data  (next_d),
      .data_o     (data_w[g]),
      .hit_o      (hit_w[g]),
      .sel_data_o (sel_w[g])
    );
  end

  always_comb begin
    rd_val = '0;
    fpos   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_val = rd_val | sel_w[i];
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit_w[i]) fpos = POS_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      cmd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_chan.ready && st_r != ST_DONE) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (in_accept) begin
            op_r  <= in_chan.func;
            key_r <= key_in;
            ok_r  <= ok_nxt;
            cmd_r <= cmd_nxt;
            cnt_r <= cnt_nxt;
            st_r  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cmd_r <= '0;
          st_r  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= (op_r == FN_LOCATE) ? (|hit_w) : ok_r;
            out_value_r <= (op_r == FN_READ && ok_r) ? VAL_W'(signed'(rd_val)) : '0;
            out_fpos_r  <= (op_r == FN_LOCATE) ? fpos : '0;
            out_len_r   <= LEN_W'(cnt_r);
            out_empty_r <= (cnt_r == '0);
            st_r        <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.ok             = out_ok_r;
  assign out_chan.value_out      = out_value_r;
  assign out_chan.found_position = out_fpos_r;
  assign out_chan.length         = out_len_r;
  assign out_chan.empty_res      = out_empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_chan.func == FN_CLEAR |=> cnt_r == '0)
    else $error("clear left entries");

  a_full_insert_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_chan.func == FN_INSERT && cnt_r == DEPTH_C |=> $stable(cnt_r))
    else $error("insert into full list changed count");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDLE |-> !(cmd_r.ins || cmd_r.del || cmd_r.rd || cmd_r.loc))
    else $error("cell command active while idle");

  a_read_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_DONE && op_r == FN_READ && ok_r |-> $onehot(hit_w))
    else $error("read selected other than one cell");

endmodule

### bench/positional_list_engine_tb.sv
module positional_list_engine_tb;
  import pl_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [FUNC_W-1:0] FN_RSVD_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } request_t;

  typedef struct {
    logic                    ok;
    logic signed [VAL_W-1:0] value_out;
    logic [POS_W-1:0]        found_position;
    logic [LEN_W-1:0]        length;
    logic                    empty_res;
  } answer_t;

  typedef struct {
    request_t rq;
    bit       typed;
    answer_t  want;
  } plan_row_t;

  typedef enum int {BLEND_GROW, BLEND_QUERY, BLEND_SHRINK, BLEND_ANY} blend_t;

  logic clk = 1'b0;
  logic rst_n;

  pl_in_if  req_bus();
  pl_out_if rsp_bus();

  positional_list_engine #(.DEPTH(LIST_DEPTH), .DATA_WIDTH(VAL_W)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (req_bus),
    .out_chan(rsp_bus)
  );

  logic signed [VAL_W-1:0] list_vals [0:LIST_DEPTH-1];
  int        list_len = 0;
  answer_t   pending_answers [$];
  plan_row_t plan [$];
  int        err_count = 0;
  bit        quiet = 1'b0;
  bit        holding = 1'b0;
  int        rx_gap = 0;
  event      hold_go;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic answer_t apply_request(request_t rq);
    answer_t a;
    int p;
    a = '{ok: 1'b0, value_out: '0, found_position: '0, length: '0, empty_res: 1'b0};
    p = int'(rq.position);
    case (rq.func)
      FN_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < LIST_DEPTH) begin
          for (int i = list_len; i >= p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p-1] = rq.value;
          list_len++;
          a.ok = 1'b1;
        end
      end
      FN_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          for (int i = p; i < list_len; i++) list_vals[i-1] = list_vals[i];
          list_len--;
          a.ok = 1'b1;
        end
      end
      FN_READ: begin
        if (p >= 1 && p <= list_len) begin
          a.value_out = list_vals[p-1];
          a.ok = 1'b1;
        end
      end
      FN_LOCATE: begin
        for (int i = 0; i < list_len; i++) begin
          if (!a.ok && list_vals[i] == rq.value) begin
            a.found_position = POS_W'(i + 1);
            a.ok = 1'b1;
          end
        end
      end
      FN_CLEAR: begin
        list_len = 0;
        a.ok = 1'b1;
      end
      default: ;
    endcase
    a.length = LEN_W'(list_len);
    a.empty_res = (list_len == 0);
    return a;
  endfunction

  task automatic send_word(request_t rq, bit typed, answer_t want);
    int gap;
    answer_t pred;
    gap = quiet ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.func = rq.func;
    req_bus.position = rq.position;
    req_bus.value_in = rq.value;
    req_bus.valid = 1'b1;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    pred = apply_request(rq);
    pending_answers.push_back(typed ? want : pred);
  endtask

  task automatic idle_until_drained();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(logic [FUNC_W-1:0] func, int pos, logic signed [VAL_W-1:0] val,
                         bit typed, bit ok, logic signed [VAL_W-1:0] vout, int len);
    plan_row_t r;
    r.rq = '{func: func, position: POS_W'(pos), value: val};
    r.typed = typed;
    r.want = '{ok: ok, value_out: vout, found_position: '0, length: LEN_W'(len),
               empty_res: (len == 0)};
    plan.push_back(r);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $signed(VAL_W'($urandom_range(0, 7))) - 4;
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom);
  endfunction

  function automatic request_t pick_request(blend_t blend);
    request_t rq;
    int r, t_ins, t_del, t_rd, t_loc, t_clr, top;
    case (blend)
      BLEND_GROW:   begin t_ins = 80; t_del = 85; t_rd = 92; t_loc = 98; t_clr = 98; end
      BLEND_SHRINK: begin t_ins = 10; t_del = 70; t_rd = 82; t_loc = 96; t_clr = 97; end
      BLEND_QUERY:  begin t_ins = 10; t_del = 20; t_rd = 60; t_loc = 95; t_clr = 96; end
      default:      begin t_ins = 35; t_del = 60; t_rd = 75; t_loc = 90; t_clr = 93; end
    endcase
    r = $urandom_range(0, 99);
    if (r < t_ins) rq.func = FN_INSERT;
    else if (r < t_del) rq.func = FN_DELETE;
    else if (r < t_rd) rq.func = FN_READ;
    else if (r < t_loc) rq.func = FN_LOCATE;
    else if (r < t_clr) rq.func = FN_CLEAR;
    else begin
      case ($urandom_range(0, 2))
        0: rq.func = FN_RSVD_5;
        1: rq.func = FN_RSVD_6;
        default: rq.func = FN_RSVD_7;
      endcase
    end
    top = (rq.func == FN_INSERT) ? list_len + 1 : list_len;
    r = $urandom_range(0, 99);
    if (r < 85) rq.position = POS_W'($urandom_range(1, (top < 1) ? 1 : top));
    else if (r < 90) rq.position = '0;
    else if (r < 95) rq.position = POS_W'(top + $urandom_range(1, 2));
    else rq.position = POS_W'($urandom_range(0, 127));
    if (rq.func == FN_LOCATE && list_len > 0 && $urandom_range(0, 99) < 65)
      rq.value = list_vals[$urandom_range(0, list_len - 1)];
    else
      rq.value = pick_value();
    return rq;
  endfunction

  always @(posedge clk) begin : watch_results
    answer_t want;
    if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected word", rsp_bus.value_out, '0);
      end else begin
        want = pending_answers.pop_front();
        if (rsp_bus.ok !== want.ok)
          report_mismatch("ok", VAL_W'(rsp_bus.ok), VAL_W'(want.ok));
        if (rsp_bus.value_out !== want.value_out)
          report_mismatch("value_out", rsp_bus.value_out, want.value_out);
        if (rsp_bus.found_position !== want.found_position)
          report_mismatch("found_position", VAL_W'(rsp_bus.found_position),
                          VAL_W'(want.found_position));
        if (rsp_bus.length !== want.length)
          report_mismatch("length", VAL_W'(rsp_bus.length), VAL_W'(want.length));
        if (rsp_bus.empty_res !== want.empty_res)
          report_mismatch("empty_res", VAL_W'(rsp_bus.empty_res), VAL_W'(want.empty_res));
      end
      rx_gap = quiet ? 0 : $urandom_range(0, 7);
    end
  end

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holding) begin
        rsp_bus.ready = 1'b0;
      end else if (rx_gap > 0) begin
        rsp_bus.ready = 1'b0;
        rx_gap--;
      end else begin
        rsp_bus.ready = (rst_n === 1'b1);
      end
    end
  end

  initial begin
    forever begin
      @(hold_go);
      @(posedge clk);
      holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding = 1'b0;
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    request_t rq;
    answer_t none;
    int items;
    rst_n = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.func = FN_INSERT;
    req_bus.position = '0;
    req_bus.value_in = '0;
    none = '{ok: 1'b0, value_out: '0, found_position: '0, length: '0, empty_res: 1'b0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_row(FN_READ,   1,   32'sd0,          1, 0, 32'sd0,          0);
    add_row(FN_DELETE, 1,   32'sd0,          1, 0, 32'sd0,          0);
    add_row(FN_LOCATE, 0,   32'sd0,          1, 0, 32'sd0,          0);
    add_row(FN_INSERT, 0,   32'sd5,          1, 0, 32'sd0,          0);
    add_row(FN_INSERT, 2,   32'sd5,          1, 0, 32'sd0,          0);
    add_row(FN_INSERT, 1,   32'sh7fff_ffff,  1, 1, 32'sd0,          1);
    add_row(FN_INSERT, 1,   32'sh8000_0000,  1, 1, 32'sd0,          2);
    add_row(FN_READ,   1,   32'sd0,          1, 1, 32'sh8000_0000,  2);
    add_row(FN_READ,   2,   32'sd0,          1, 1, 32'sh7fff_ffff,  2);
    add_row(FN_READ,   0,   32'sd0,          1, 0, 32'sd0,          2);
    add_row(FN_READ,   3,   32'sd0,          1, 0, 32'sd0,          2);
    add_row(FN_READ,   127, 32'sd0,          1, 0, 32'sd0,          2);
    add_row(FN_INSERT, 3,   -32'sd1,         1, 1, 32'sd0,          3);
    add_row(FN_INSERT, 2,   -32'sd1,         0, 0, 32'sd0,          0);
    add_row(FN_LOCATE, 0,   -32'sd1,         0, 0, 32'sd0,          0);
    add_row(FN_LOCATE, 0,   32'sd12345,      0, 0, 32'sd0,          0);
    add_row(FN_LOCATE, 0,   32'sh7fff_ffff,  0, 0, 32'sd0,          0);
    add_row(FN_DELETE, 0,   32'sd0,          1, 0, 32'sd0,          4);
    add_row(FN_DELETE, 5,   32'sd0,          1, 0, 32'sd0,          4);
    add_row(FN_DELETE, 2,   32'sd0,          0, 0, 32'sd0,          0);
    add_row(FN_RSVD_5, 1,   32'sd9,          1, 0, 32'sd0,          3);
    add_row(FN_RSVD_6, 2,   32'sd0,          1, 0, 32'sd0,          3);
    add_row(FN_RSVD_7, 127, -32'sd1,         1, 0, 32'sd0,          3);
    add_row(FN_CLEAR,  0,   32'sd0,          1, 1, 32'sd0,          0);
    add_row(FN_CLEAR,  127, 32'sd0,          1, 1, 32'sd0,          0);
    add_row(FN_INSERT, 127, 32'sd0,          1, 0, 32'sd0,          0);
    foreach (plan[k]) send_word(plan[k].rq, plan[k].typed, plan[k].want);
    idle_until_drained();

    // fill to capacity, then push against the full list
    while (list_len < LIST_DEPTH) begin
      rq = '{func: FN_INSERT, position: POS_W'($urandom_range(1, list_len + 1)),
             value: pick_value()};
      send_word(rq, 0, none);
    end
    repeat (6) begin
      rq = '{func: FN_INSERT, position: POS_W'($urandom_range(0, 127)), value: pick_value()};
      send_word(rq, 0, none);
    end
    rq = '{func: FN_READ, position: POS_W'(LIST_DEPTH), value: '0};
    send_word(rq, 0, none);

    items = 0;
    for (int ph = 0; ph < 14; ph++) begin
      if (ph % 3 == 0) idle_until_drained();
      quiet = (ph % 5 == 2);
      if (ph == 7) -> hold_go;
      repeat (48) begin
        rq = pick_request(blend_t'(ph % 4));
        send_word(rq, 0, none);
        items++;
      end
    end

    @(negedge clk);
    req_bus.valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### positional_list_engine.f
hdl/pl_pkg.sv
hdl/pl_in_if.sv
hdl/pl_out_if.sv
hdl/pl_cell.sv
hdl/positional_list_engine.sv
bench/positional_list_engine_tb.sv
